// File: design/ltps_pkg.sv
// Package for the line table predecessor search block.
// Holds field widths, command codes and the controller/datapath interface structs.
// No dependencies.
package ltps_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int CNT_W  = 11;
	localparam int SLOT_W = 10;
	localparam int POS_W  = 64;
	localparam int LINE_W = 32;
	// Search indexes: lo + hi must fit, and both stay at or below the saturated count.
	localparam int IDX_W  = CNT_W + 1;
	localparam int TDATA_IN_W  = 176;
	localparam int TDATA_OUT_W = 32;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [LINE_W-1:0] LINE_NONE = '1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write;    // store the incoming entry
		logic start;    // latch the query and initialize the search window
		logic set_zero; // empty table, answer zero
		logic set_none; // search window exhausted, answer all ones
		logic probe;    // issue the table reads at the window midpoint
		logic compare;  // evaluate the read data and narrow the window
		logic load_out; // move the result into the output register
	} ltps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_zero;
		logic exhausted;
		logic cmp_done;
		logic out_free;
	} ltps_status_t;

endpackage

// File: design/ltps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the position and line stores. No dependencies.
module ltps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/ltps_ctrl.sv
// Controller state machine of the line table predecessor search.
// Sequences writes, search probes and result hand-off; depends on ltps_pkg.
module ltps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_command,
	output logic                  s_tready,
	input  ltps_pkg::ltps_status_t status,
	output ltps_pkg::ltps_cmd_t    cmd
);
	import ltps_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PROBE = 4'b0010,
		S_CMP   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && (s_command == CMD_WRITE)) begin
					cmd.write = 1'b1;
				end
				if (accept && (s_command == CMD_QUERY)) begin
					cmd.start = 1'b1;
					state_d   = S_PROBE;
				end
			end
			S_PROBE: begin
				if (status.n_zero) begin
					cmd.set_zero = 1'b1;
					state_d      = S_DONE;
				end else if (status.exhausted) begin
					cmd.set_none = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.probe = 1'b1;
					state_d   = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = status.cmp_done ? S_DONE : S_PROBE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/ltps_dpath.sv
// Datapath of the line table predecessor search: count register, table memories,
// search window, comparators and output register. Depends on ltps_pkg and ltps_ram.
module ltps_dpath #(
	parameter int TABLE_DEPTH = ltps_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ltps_pkg::ltps_cmd_t            cmd,
	output ltps_pkg::ltps_status_t         status,
	input  logic                          cfg_valid,
	input  logic [ltps_pkg::CNT_W-1:0]    cfg_data,
	input  logic [ltps_pkg::SLOT_W-1:0]   slot,
	input  logic [ltps_pkg::POS_W-1:0]    entry_position,
	input  logic [ltps_pkg::LINE_W-1:0]   entry_line,
	input  logic [ltps_pkg::POS_W-1:0]    query_index,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [ltps_pkg::LINE_W-1:0]   line_number
);
	import ltps_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [CNT_W-1:0]  table_count_q;
	logic [IDX_W-1:0]  n_c, n_q, lo_q, hi_q, mid_q, mid_c, nxt_c;
	logic [POS_W-1:0]  key_q;
	logic [LINE_W-1:0] res_q, cmp_res, out_data_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_mid, pos_nxt;
	logic [LINE_W-1:0] line_rd;
	logic [AW+SLOT_W-1:0] slot_ext;
	logic [AW+IDX_W-1:0]  mid_ext, nxt_ext;
	logic [AW-1:0]     waddr, raddr_mid, raddr_nxt;
	logic              slot_ok, we;
	logic              single, above, is_last, nxt_above;

	// Writes to a slot outside the table are dropped.
	assign slot_ext = {{AW{1'b0}}, slot};
	assign waddr    = slot_ext[AW-1:0];
	assign slot_ok  = (32'(slot) < 32'(TABLE_DEPTH));
	assign we       = cmd.write && slot_ok;

	// Count saturates at the table depth.
	always_comb begin
		if (32'(table_count_q) > 32'(TABLE_DEPTH)) begin
			n_c = IDX_W'(TABLE_DEPTH);
		end else begin
			n_c = IDX_W'(table_count_q);
		end
	end

	assign mid_c     = IDX_W'((lo_q + hi_q) >> 1);
	assign nxt_c     = mid_c + IDX_W'(1);
	assign mid_ext   = {{AW{1'b0}}, mid_c};
	assign nxt_ext   = {{AW{1'b0}}, nxt_c};
	assign raddr_mid = mid_ext[AW-1:0];
	assign raddr_nxt = nxt_ext[AW-1:0];

	// The position store is kept twice so both neighbors are read in the same cycle.
	ltps_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_pos_mid (
		.clk(clk), .we(we), .waddr(waddr), .wdata(entry_position),
		.re(cmd.probe), .raddr(raddr_mid), .rdata(pos_mid)
	);

	ltps_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_pos_nxt (
		.clk(clk), .we(we), .waddr(waddr), .wdata(entry_position),
		.re(cmd.probe), .raddr(raddr_nxt), .rdata(pos_nxt)
	);

	ltps_ram #(.WIDTH(LINE_W), .DEPTH(TABLE_DEPTH)) u_line (
		.clk(clk), .we(we), .waddr(waddr), .wdata(entry_line),
		.re(cmd.probe), .raddr(raddr_mid), .rdata(line_rd)
	);

	assign single    = (n_q == IDX_W'(1));
	assign above     = (pos_mid > key_q);
	assign nxt_above = (pos_nxt > key_q);
	assign is_last   = (mid_q == (n_q - IDX_W'(1)));

	// A single-entry table answers its only line whatever the key.
	assign status.cmp_done = single || (above && (mid_q == '0)) ||
		(!above && (is_last || nxt_above));
	assign cmp_res = (above && !single) ? '0 : line_rd;

	assign status.n_zero    = (n_q == '0);
	assign status.exhausted = (lo_q > hi_q) || (mid_c >= n_q);
	assign status.out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= query_index;
			n_q   <= n_c;
			lo_q  <= '0;
			hi_q  <= n_c;
		end
		if (cmd.probe) begin
			mid_q <= mid_c;
		end
		if (cmd.compare && !status.cmp_done) begin
			if (above) begin
				hi_q <= mid_q - IDX_W'(1);
			end else begin
				lo_q <= mid_q + IDX_W'(1);
			end
		end
		if (cmd.set_zero) begin
			res_q <= '0;
		end else if (cmd.set_none) begin
			res_q <= LINE_NONE;
		end else if (cmd.compare && status.cmp_done) begin
			res_q <= cmp_res;
		end
		if (cmd.load_out) begin
			out_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				table_count_q <= cfg_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid    = out_valid_q;
	assign line_number = out_data_q;

endmodule

// File: design/line_table_predecessor_search.sv
// Line table predecessor search, top level. Timing: a write transfer is stored in the
// cycle it is accepted; a query walks at most clog2(count)+1 probes, each a registered
// table read in the probe state feeding the compare in the compare state, then hands
// its answer to the output register. Writes are accepted every cycle while the
// controller is idle; queries one at a time. Reset clears the controller, the count and
// the output valid; the table is undefined until written and gets no clearing pass.
module line_table_predecessor_search #(
	parameter int TABLE_DEPTH = ltps_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration: table_count.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ltps_pkg::CNT_W-1:0]         cfg_data,
	// Input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata from bit 0: slot[9:0], entry_position[73:10], entry_line[105:74],
	// query_index[169:106], zero fill[175:170].
	input  logic [ltps_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
	// tuser: command (0 write an entry, 1 query).
	input  logic                               s_axis_tuser,
	// Output stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata from bit 0: line_number[31:0].
	output logic [ltps_pkg::TDATA_OUT_W-1:0]   m_axis_tdata
);
	import ltps_pkg::*;

	ltps_cmd_t    cmd;
	ltps_status_t status;

	logic [SLOT_W-1:0] slot;
	logic [POS_W-1:0]  entry_position, query_index;
	logic [LINE_W-1:0] entry_line, line_number;

	// The user must let the count register change only while the block is idle; the
	// block does not enforce this, and every configuration transfer is taken at once.
	assign cfg_ready = 1'b1;

	assign slot           = s_axis_tdata[9:0];
	assign entry_position = s_axis_tdata[73:10];
	assign entry_line     = s_axis_tdata[105:74];
	assign query_index    = s_axis_tdata[169:106];

	// The controller takes input transfers only while idle; writes return to idle
	// at once, a query walks the probe/compare loop and then waits in its done
	// state until the output register can take the answer.
	ltps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_command(s_axis_tuser),
		.s_tready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the count, the table, the search window and the
	// output register that lets the next transfer in while an answer waits.
	ltps_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.slot          (slot),
		.entry_position(entry_position),
		.entry_line    (entry_line),
		.query_index   (query_index),
		.m_tready      (m_axis_tready),
		.m_tvalid      (m_axis_tvalid),
		.line_number   (line_number)
	);

	assign m_axis_tdata = line_number;

`ifndef NO_ASSERTIONS
	// A pending answer is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("output register loaded while a result was still pending");

	// Read data is consumed in the cycle right after the read is issued.
	a_probe_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |=> cmd.compare)
		else $error("compare did not follow a probe");

	// No input transfer is taken while a search is running.
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe || cmd.compare) |-> !s_axis_tready)
		else $error("input ready while a search is in progress");

	// Only one datapath action is commanded at a time.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write, cmd.start, cmd.set_zero, cmd.set_none,
			cmd.probe, cmd.compare, cmd.load_out}))
		else $error("conflicting datapath commands");
`endif

endmodule
